[src/pcx_pkg.sv]
package pcx_pkg;

    localparam int POS_BITS_DEF = 20;
    localparam int CFG_W        = 21;
    localparam int CNT_W        = 6;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [CFG_W-1:0] PIXELS_RESET    = CFG_W'(64000);
    localparam logic [7:0]       COUNT_THRESHOLD = 8'hBF;
    localparam logic [7:0]       COUNT_MASK      = 8'h3F;

    // one run to be expanded by the back end
    typedef struct packed {
        logic [7:0]       value;
        logic [CNT_W-1:0] count;
    } run_cmd_t;

endpackage

[src/pcx_front.sv]
module pcx_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      code_byte,
    input  logic            q_full,
    output logic            q_push,
    output pcx_pkg::run_cmd_t q_cmd
);
    import pcx_pkg::*;

    logic             await_value_reg;
    logic             await_value_next;
    logic [CNT_W-1:0] run_length_reg;
    logic [CNT_W-1:0] run_length_next;
    logic             accept;
    logic             is_count;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign is_count = code_byte > COUNT_THRESHOLD;

    always_comb
    begin
        await_value_next = await_value_reg;
        run_length_next  = run_length_reg;
        q_push           = 1'b0;
        q_cmd.value      = code_byte;
        q_cmd.count      = CNT_W'(1);
        if (accept)
        begin
            if (!await_value_reg)
            begin
                if (is_count)
                begin
                    run_length_next  = CNT_W'(code_byte & COUNT_MASK);
                    await_value_next = 1'b1;
                end
                else
                begin
                    q_push = 1'b1;
                end
            end
            else
            begin
                // value byte of a run; an empty run is dropped here
                await_value_next = 1'b0;
                run_length_next  = '0;
                q_cmd.count      = run_length_reg;
                q_push           = (run_length_reg != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            await_value_reg <= 1'b0;
            run_length_reg  <= '0;
        end
        else
        begin
            await_value_reg <= await_value_next;
            run_length_reg  <= run_length_next;
        end
    end

endmodule

[src/pcx_queue.sv]
module pcx_queue #(
    parameter int DEPTH = pcx_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pcx_pkg::run_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output pcx_pkg::run_cmd_t head_cmd
);
    import pcx_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    run_cmd_t        mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   fill_next;

    assign full       = (fill_reg == CW'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("queue fill count out of range");

endmodule

[src/pcx_back.sv]
module pcx_back #(
    parameter int POSITION_BITS = pcx_pkg::POS_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pcx_pkg::CFG_W-1:0] image_pixels,
    input  logic                      q_valid,
    input  pcx_pkg::run_cmd_t         q_cmd,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                pixel,
    output logic                      run_last,
    output logic                      image_end
);
    import pcx_pkg::*;

    localparam int P  = POSITION_BITS;
    localparam int WW = (P + 1 > CFG_W) ? P + 1 : CFG_W;

    logic [WW-1:0]    img_w;
    logic [WW-1:0]    cap_w;
    logic [WW-1:0]    img_m1_w;
    logic [P-1:0]     last_pos;
    logic [P-1:0]     last_pos_reg;

    logic             cur_valid_reg;
    logic             cur_valid_next;
    logic [7:0]       cur_value_reg;
    logic [7:0]       cur_value_next;
    logic [CNT_W-1:0] cur_cnt_reg;
    logic [CNT_W-1:0] cur_cnt_next;
    logic [P-1:0]     pos_reg;
    logic [P-1:0]     pos_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_pixel_reg;
    logic             out_last_reg;
    logic             out_end_reg;

    logic             emit;
    logic             at_end;
    logic             last_of_run;

    // index of the final pixel: size zero acts as one, size is capped at 2^P
    always_comb
    begin
        img_w    = WW'(image_pixels);
        cap_w    = WW'(1) << P;
        img_m1_w = img_w - WW'(1);
        if (img_w == '0)
        begin
            last_pos = '0;
        end
        else if (img_w > cap_w)
        begin
            last_pos = '1;
        end
        else
        begin
            last_pos = img_m1_w[P-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        last_pos_reg <= last_pos;
    end

    assign emit        = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign at_end      = pos_reg >= last_pos_reg;
    assign last_of_run = (cur_cnt_reg == CNT_W'(1)) || at_end;
    assign q_pop       = q_valid && (!cur_valid_reg || (emit && last_of_run));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_value_next = cur_value_reg;
        cur_cnt_next   = cur_cnt_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (emit)
        begin
            out_valid_next = 1'b1;
            pos_next       = at_end ? '0 : pos_reg + P'(1);
            cur_cnt_next   = cur_cnt_reg - CNT_W'(1);
            // a run clamped at the image end drops its remainder
            if (last_of_run)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            cur_value_next = q_cmd.value;
            cur_cnt_next   = q_cmd.count;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_value_reg <= cur_value_next;
        if (emit)
        begin
            out_pixel_reg <= cur_value_reg;
            out_last_reg  <= last_of_run;
            out_end_reg   <= at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_cnt_reg   <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cur_cnt_reg   <= cur_cnt_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = out_pixel_reg;
    assign run_last  = out_last_reg;
    assign image_end = out_end_reg;

    a_cur_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_cnt_reg != '0))
        else $error("active run with zero count");
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_end_reg) |-> out_last_reg)
        else $error("image end beat not marked as last of run");
    a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && cur_valid_reg) |-> (emit && last_of_run))
        else $error("run loaded over an unfinished run");

endmodule

[src/pcx_rle_decoder_top.sv]
// pcx run-length decoder
// input channel: one compressed byte per beat on code_byte (in_valid / in_stall).
// a byte above 0xbf is a count byte (low six bits = run length) and produces no
// output; the byte after it is repeated that many times. any other byte is one
// literal pixel. an empty run produces nothing.
// output channel: one pixel per beat on pixel with run_last and image_end
// (out_valid / out_stall). image_end marks the final pixel of an image and a run
// crossing the image end is cut there.
// cfg_wr_en / cfg_wr_data load the image size; write it only while idle.
// a run passes the run queue, the current-run register and the output register.
// throughput: one pixel per cycle while out_stall is low, set by the expansion
// unit, which keeps a run until its last pixel is out; a count byte uses a beat.
// a four-entry run queue lets input continue during a run; in_stall rises when
// it fills. when out_stall is high a pending output beat holds and the expansion waits.
// reset clears the queue, the pending count byte and the pixel position and sets
// the image size to 64000.
module pcx_rle_decoder_top #(
    parameter int POSITION_BITS = pcx_pkg::POS_BITS_DEF,
    parameter int QUEUE_DEPTH   = pcx_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [pcx_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                code_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                pixel,
    output logic                      run_last,
    output logic                      image_end
);
    import pcx_pkg::*;

    logic [CFG_W-1:0] image_pixels_reg;
    logic             q_full;
    logic             q_push;
    run_cmd_t         push_cmd;
    logic             q_pop;
    logic             q_valid;
    run_cmd_t         head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_pixels_reg <= PIXELS_RESET;
        end
        else if (cfg_wr_en)
        begin
            image_pixels_reg <= cfg_wr_data;
        end
    end

    pcx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .code_byte (code_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    pcx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    pcx_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_pixels (image_pixels_reg),
        .q_valid      (q_valid),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel        (pixel),
        .run_last     (run_last),
        .image_end    (image_end)
    );

endmodule
